### src/qsed_pkg.sv
// Package for the quoted string escape decoder: widths, character codes,
// mode and result-kind enums, the shared structs and the digit helpers.
// No dependencies; every other file in src/ refers to it by scoped names.
`timescale 1ns / 1ps

package qsed_pkg;

   localparam int CH_W    = 8;
   localparam int KIND_W  = 3;
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 9;

   // Character codes used by the decoder
   localparam logic [CH_W-1:0] CHR_QUOTE  = 8'h27;
   localparam logic [CH_W-1:0] CHR_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CHR_BSLASH = 8'h5C;
   localparam logic [CH_W-1:0] CHR_BTICK  = 8'h60;
   localparam logic [CH_W-1:0] CHR_AMP    = 8'h26;
   localparam logic [CH_W-1:0] CHR_0      = 8'h30;
   localparam logic [CH_W-1:0] CHR_7      = 8'h37;
   localparam logic [CH_W-1:0] CHR_9      = 8'h39;
   localparam logic [CH_W-1:0] CHR_LC_A   = 8'h61;
   localparam logic [CH_W-1:0] CHR_LC_B   = 8'h62;
   localparam logic [CH_W-1:0] CHR_LC_F   = 8'h66;
   localparam logic [CH_W-1:0] CHR_LC_N   = 8'h6E;
   localparam logic [CH_W-1:0] CHR_LC_R   = 8'h72;
   localparam logic [CH_W-1:0] CHR_LC_T   = 8'h74;
   localparam logic [CH_W-1:0] CHR_LC_V   = 8'h76;
   localparam logic [CH_W-1:0] CHR_LC_X   = 8'h78;
   localparam logic [CH_W-1:0] CHR_UC_A   = 8'h41;
   localparam logic [CH_W-1:0] CHR_UC_F   = 8'h46;

   // Control codes produced by the letter escapes
   localparam logic [CH_W-1:0] CODE_BEL = 8'd7;
   localparam logic [CH_W-1:0] CODE_BS  = 8'd8;
   localparam logic [CH_W-1:0] CODE_HT  = 8'd9;
   localparam logic [CH_W-1:0] CODE_LF  = 8'd10;
   localparam logic [CH_W-1:0] CODE_VT  = 8'd11;
   localparam logic [CH_W-1:0] CODE_FF  = 8'd12;
   localparam logic [CH_W-1:0] CODE_CR  = 8'd13;

   typedef enum logic [MODE_W-1:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_HEX1  = 3'd2,
      MODE_HEX2  = 3'd3,
      MODE_OCT2  = 3'd4,
      MODE_OCT3  = 3'd5
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE   = 3'd0,
      KIND_END    = 3'd1,
      KIND_EOF    = 3'd2,
      KIND_BADHEX = 3'd3,
      KIND_BADOCT = 3'd4,
      KIND_BADESC = 3'd5
   } kind_type;

   // Request held in the input register
   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ch;
      logic            at_end;
   } item_type;

   // Decoder state carried between requests
   typedef struct packed {
      mode_type           mode;
      logic [VALUE_W-1:0] digit_value;
      logic               digit_bad;
   } state_type;

   // One decoded result, valid marks that the request produced one
   typedef struct packed {
      logic            valid;
      kind_type        kind;
      logic [CH_W-1:0] data;
   } result_type;

   localparam state_type STATE_RESET = '{mode: MODE_PLAIN, digit_value: '0, digit_bad: 1'b0};

   // Hex digit value; bit 4 set means not a hex digit
   function automatic logic [4:0] hex_digit(input logic [CH_W-1:0] c);
      logic [4:0] d;
      if (c inside {[CHR_0:CHR_9]}) begin
         d = {1'b0, c[3:0]};
      end else if (c inside {[CHR_LC_A:CHR_LC_F], [CHR_UC_A:CHR_UC_F]}) begin
         d = {1'b0, c[3:0] + 4'd9};
      end else begin
         d = 5'd16;
      end
      return d;
   endfunction

   function automatic logic is_oct_digit(input logic [CH_W-1:0] c);
      return c inside {[CHR_0:CHR_7]};
   endfunction

endpackage

### src/qsed_if.sv
// Channel interfaces for the quoted string escape decoder: request and
// response, each with valid/ready and its payload. Depends on qsed_pkg.
`timescale 1ns / 1ps

interface qsed_req_if;
   logic                       valid;
   logic                       ready;
   logic [qsed_pkg::CH_W-1:0]  ch;
   logic                       at_end;
   modport source (output valid, ch, at_end, input ready);
   modport sink   (input valid, ch, at_end, output ready);
endinterface

interface qsed_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [qsed_pkg::KIND_W-1:0] kind;
   logic [qsed_pkg::CH_W-1:0]   data;
   modport source (output valid, kind, data, input ready);
   modport sink   (input valid, kind, data, output ready);
endinterface

### src/qsed_in_reg.sv
// Input register of the decoder: captures one request per cycle and holds it
// until the decode stage takes it. Depends on qsed_pkg and qsed_req_if.
`timescale 1ns / 1ps

module qsed_in_reg (
   input  logic                clock,
   input  logic                reset,
   qsed_req_if.sink            req_chan,
   input  logic                take,
   output qsed_pkg::item_type  item
);

   qsed_pkg::item_type item_ff, item_in;

   // Free when empty or when the held request moves on this cycle
   assign req_chan.ready = !item_ff.valid || take;

   always_comb begin
      item_in = item_ff;
      if (req_chan.valid && req_chan.ready) begin
         item_in.valid  = 1'b1;
         item_in.ch     = req_chan.ch;
         item_in.at_end = req_chan.at_end;
      end else if (take) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.ch     <= item_in.ch;
      item_ff.at_end <= item_in.at_end;
   end

   assign item = item_ff;

endmodule

### src/qsed_step.sv
// Decode step: from the held character and the current state, works out the
// next state and the result, if any. Pure logic. Depends on qsed_pkg.
`timescale 1ns / 1ps

module qsed_step (
   input  qsed_pkg::item_type   item,
   input  qsed_pkg::state_type  state,
   output qsed_pkg::state_type  state_next,
   output qsed_pkg::result_type result
);

   logic [4:0]                      hex_d;
   logic                            hex_ok;
   logic                            oct_ok;
   logic [qsed_pkg::VALUE_W-1:0]    hex_value;
   logic [qsed_pkg::VALUE_W-1:0]    oct_value;
   logic                            hex_bad;
   logic                            oct_bad;
   logic                            hex_reject;
   logic                            oct_reject;
   logic [qsed_pkg::VALUE_W-1:0]    first_oct;

   // Digit collection; a bad digit leaves the value as it was
   assign hex_d      = qsed_pkg::hex_digit(item.ch);
   assign hex_ok     = !hex_d[4];
   assign oct_ok     = qsed_pkg::is_oct_digit(item.ch);
   assign hex_value  = hex_ok ? {state.digit_value[4:0], hex_d[3:0]} : state.digit_value;
   assign oct_value  = oct_ok ? {state.digit_value[5:0], item.ch[2:0]} : state.digit_value;
   assign hex_bad    = state.digit_bad || !hex_ok;
   assign oct_bad    = state.digit_bad || !oct_ok;
   assign first_oct  = {{(qsed_pkg::VALUE_W-3){1'b0}}, item.ch[2:0]};

   // Final check: no bad digit, nonzero, fits a byte
   assign hex_reject = hex_bad || (hex_value == '0) || hex_value[qsed_pkg::VALUE_W-1];
   assign oct_reject = oct_bad || (oct_value == '0) || oct_value[qsed_pkg::VALUE_W-1];

   // Next state
   always_comb begin
      state_next = state;
      if (item.at_end) begin
         state_next = qsed_pkg::STATE_RESET;
      end else begin
         case (state.mode)
            qsed_pkg::MODE_ESC: begin
               state_next.mode = qsed_pkg::MODE_PLAIN;
               if (item.ch == qsed_pkg::CHR_LC_X) begin
                  state_next.mode        = qsed_pkg::MODE_HEX1;
                  state_next.digit_value = '0;
                  state_next.digit_bad   = 1'b0;
               end else if (oct_ok) begin
                  state_next.mode        = qsed_pkg::MODE_OCT2;
                  state_next.digit_value = first_oct;
                  state_next.digit_bad   = 1'b0;
               end
            end
            qsed_pkg::MODE_HEX1: begin
               state_next.mode        = qsed_pkg::MODE_HEX2;
               state_next.digit_value = hex_value;
               state_next.digit_bad   = hex_bad;
            end
            qsed_pkg::MODE_OCT2: begin
               state_next.mode        = qsed_pkg::MODE_OCT3;
               state_next.digit_value = oct_value;
               state_next.digit_bad   = oct_bad;
            end
            qsed_pkg::MODE_HEX2, qsed_pkg::MODE_OCT3: begin
               state_next = qsed_pkg::STATE_RESET;
            end
            default: begin
               state_next.mode = (item.ch == qsed_pkg::CHR_BSLASH) ?
                                 qsed_pkg::MODE_ESC : qsed_pkg::MODE_PLAIN;
            end
         endcase
      end
   end

   // Result
   always_comb begin
      result.valid = 1'b0;
      result.kind  = qsed_pkg::KIND_BYTE;
      result.data  = '0;
      if (item.at_end) begin
         result.valid = 1'b1;
         result.kind  = qsed_pkg::KIND_EOF;
      end else begin
         case (state.mode)
            qsed_pkg::MODE_ESC: begin
               result.valid = 1'b1;
               case (item.ch)
                  qsed_pkg::CHR_LC_A: result.data = qsed_pkg::CODE_BEL;
                  qsed_pkg::CHR_LC_B: result.data = qsed_pkg::CODE_BS;
                  qsed_pkg::CHR_LC_F: result.data = qsed_pkg::CODE_FF;
                  qsed_pkg::CHR_LC_N: result.data = qsed_pkg::CODE_LF;
                  qsed_pkg::CHR_LC_R: result.data = qsed_pkg::CODE_CR;
                  qsed_pkg::CHR_LC_T: result.data = qsed_pkg::CODE_HT;
                  qsed_pkg::CHR_LC_V: result.data = qsed_pkg::CODE_VT;
                  qsed_pkg::CHR_BSLASH, qsed_pkg::CHR_BTICK, qsed_pkg::CHR_DQUOTE,
                  qsed_pkg::CHR_QUOTE, qsed_pkg::CHR_AMP: begin
                     result.data = item.ch;
                  end
                  qsed_pkg::CHR_LC_X: result.valid = 1'b0;
                  default: begin
                     if (oct_ok) begin
                        result.valid = 1'b0;
                     end else begin
                        result.kind = qsed_pkg::KIND_BADESC;
                     end
                  end
               endcase
            end
            qsed_pkg::MODE_HEX1, qsed_pkg::MODE_OCT2: begin
               result.valid = 1'b0;
            end
            qsed_pkg::MODE_HEX2: begin
               result.valid = 1'b1;
               if (hex_reject) begin
                  result.kind = qsed_pkg::KIND_BADHEX;
               end else begin
                  result.data = hex_value[qsed_pkg::CH_W-1:0];
               end
            end
            qsed_pkg::MODE_OCT3: begin
               result.valid = 1'b1;
               if (oct_reject) begin
                  result.kind = qsed_pkg::KIND_BADOCT;
               end else begin
                  result.data = oct_value[qsed_pkg::CH_W-1:0];
               end
            end
            default: begin
               if (item.ch == qsed_pkg::CHR_QUOTE) begin
                  result.valid = 1'b1;
                  result.kind  = qsed_pkg::KIND_END;
               end else if (item.ch != qsed_pkg::CHR_BSLASH) begin
                  result.valid = 1'b1;
                  result.data  = item.ch;
               end
            end
         endcase
      end
   end

endmodule

### src/qsed_out_reg.sv
// Result register of the decoder: holds one decoded result until the
// response side takes it. Depends on qsed_pkg and qsed_rsp_if.
`timescale 1ns / 1ps

module qsed_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  qsed_pkg::result_type result,
   output logic                 free,
   qsed_rsp_if.source           rsp_chan
);

   qsed_pkg::result_type out_ff, out_in;

   // Room for a new result when empty or when the held one leaves now
   assign free = !out_ff.valid || rsp_chan.ready;

   always_comb begin
      out_in = out_ff;
      if (load) begin
         out_in = result;
      end else if (rsp_chan.ready) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.kind <= out_in.kind;
      out_ff.data <= out_in.data;
   end

   assign rsp_chan.valid = out_ff.valid;
   assign rsp_chan.kind  = out_ff.kind;
   assign rsp_chan.data  = out_ff.data;

endmodule

### src/quoted_string_escape_decoder.sv
// Quoted string escape decoder, top level.
// Path: an accepted request goes into the input register; it is decoded
// into the result register, which drives rsp_chan, once that has room.
// Throughput: one request per cycle, limited only by the response side.
// Reset (synchronous, active high) empties both registers and puts the
// decoder back into plain character mode with cleared digit state.
`timescale 1ns / 1ps

module quoted_string_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   qsed_req_if.sink   req_chan,
   qsed_rsp_if.source rsp_chan
);

   qsed_pkg::item_type   item;
   qsed_pkg::state_type  state_ff, state_in;
   qsed_pkg::state_type  state_next;
   qsed_pkg::result_type result;
   logic                 out_free;
   logic                 advance;

   // Held request is decoded once the result register has room
   assign advance = item.valid && out_free;

   qsed_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (advance),
      .item     (item)
   );

   qsed_step u_step (
      .item       (item),
      .state      (state_ff),
      .state_next (state_next),
      .result     (result)
   );

   // Decoder state moves only with a decoded request
   assign state_in = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qsed_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   qsed_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && result.valid),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
